[src/record_sum_averager_unit_macros.svh]
// Assertion helpers shared by the averager modules.
// Both expect clk and rst_n in scope at the point of use.
`ifndef RECORD_SUM_AVERAGER_UNIT_MACROS_SVH
`define RECORD_SUM_AVERAGER_UNIT_MACROS_SVH

// same-cycle implication
`define RSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rsa_pkg.sv]
`default_nettype none

package rsa_pkg;

  // default parameter values
  localparam int MAX_BINS_DEF    = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SUM_BITS_DEF    = 64;

  // fixed field widths
  localparam int ACTION_W    = 2;
  localparam int SEL_W       = 12;
  localparam int BIN_INDEX_W = 12;
  localparam int BIN_SUM_W   = 64;
  localparam int BINS_CFG_W  = 13;
  localparam int RECS_W      = 16;

  // config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BINS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RECS = 1'b1;

  localparam int BINS_CFG_RESET = 4096;
  localparam int RECS_CFG_RESET = 1;

  // action codes (the unused code is folded into a read at the front)
  localparam logic [ACTION_W-1:0] ACT_ACCUM = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // width of one queued work entry: op, bin address, sample, block flag
  function automatic int entry_w(input int max_bins, input int sample_bits);
    return ACTION_W + $clog2(max_bins) + sample_bits + 1;
  endfunction

endpackage

`default_nettype wire

[src/record_sum_averager_unit.sv]
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------------------
// input    | in_push / in_full         | in_action, in_sample, in_bin_select
// result   | out_empty / out_pop       | out_bin_index, out_bin_sum, out_block_done
// config   | cfg_we (no wait)          | cfg_index, cfg_data
//
// One beat per clock in and out when the result side pops every cycle.
// An accepted input beat passes the front stage, the queue and a two-step
// read-modify-write of the accumulator RAM before its result is visible.
// After reset a clearing pass zeroes the store, one bin per cycle, with in_full
// high; config writes still land. Result stalls back up through the RAM pipe
// into the 4-deep queue; in_full rises when the queue plus the front stage
// hold 4 beats, and while the clearing pass runs.
`default_nettype none

module record_sum_averager_unit
  import rsa_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // config
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  // input beats
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [ACTION_W-1:0]          in_action,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic [SEL_W-1:0]             in_bin_select,
  // result beats
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic [BIN_INDEX_W-1:0]            out_bin_index,
  output logic signed [BIN_SUM_W-1:0]       out_bin_sum,
  output logic                              out_block_done
);

  localparam int EW = entry_w(MAX_BINS, SAMPLE_BITS);

  // front -> queue -> back
  logic              f_push;
  logic [EW-1:0]     f_data;
  logic              q_valid;
  logic [EW-1:0]     q_data;
  logic [QLVL_W-1:0] q_level;
  logic              b_pop;
  logic              clr_busy;

  // Front: takes beats, folds the action code, runs the bin and record
  // counters and reduces bin_select to a store address.
  rsa_front #(
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_sample     (in_sample),
    .in_bin_select (in_bin_select),
    .clr_busy_i    (clr_busy),
    .q_level_i     (q_level),
    .q_push_o      (f_push),
    .q_data_o      (f_data)
  );

  // Short queue so a stalled result side does not stall the counters'
  // stage in the same cycle.
  rsa_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .data_i  (f_data),
    .pop_i   (b_pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .level_o (q_level)
  );

  // Back: read-modify-write of the accumulator RAM with one-deep bypass,
  // then the result register.
  rsa_back #(
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (b_pop),
    .clr_busy_o     (clr_busy),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_bin_index  (out_bin_index),
    .out_bin_sum    (out_bin_sum),
    .out_block_done (out_block_done)
  );

endmodule

`default_nettype wire

[src/rsa_front.sv]
`default_nettype none

`include "record_sum_averager_unit_macros.svh"

module rsa_front
  import rsa_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                    cfg_data,
  input  wire logic                                     in_push,
  output logic                                          in_full,
  input  wire logic [ACTION_W-1:0]                      in_action,
  input  wire logic signed [SAMPLE_BITS-1:0]            in_sample,
  input  wire logic [SEL_W-1:0]                         in_bin_select,
  input  wire logic                                     clr_busy_i,
  input  wire logic [QLVL_W-1:0]                        q_level_i,
  output logic                                          q_push_o,
  output logic [entry_w(MAX_BINS, SAMPLE_BITS)-1:0]     q_data_o
);

  localparam int AW       = $clog2(MAX_BINS);
  localparam int NBW      = $clog2(MAX_BINS + 1);
  localparam int BINS_RST = (BINS_CFG_RESET > MAX_BINS) ? MAX_BINS : BINS_CFG_RESET;

  typedef struct packed {
    logic [ACTION_W-1:0]           op;
    logic [AW-1:0]                 addr;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          done;
  } entry_t;

  // effective register values (zero and oversize folded in at write time)
  logic [NBW-1:0]    bins_eff_r;
  logic [RECS_W-1:0] recs_eff_r;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [RECS_W-1:0] rec_r, rec_nxt;

  logic                          a_valid_r;
  logic [ACTION_W-1:0]           a_op_r;
  logic signed [SAMPLE_BITS-1:0] a_sample_r;
  logic [AW-1:0]                 a_pos_r;
  logic [SEL_W-1:0]              a_sel_r;
  logic                          a_done_r;

  logic                  accept;
  logic [ACTION_W-1:0]   op_in;
  logic [AW-1:0]         pos_cur;
  logic [NBW-1:0]        pos_inc;
  logic                  rec_wrap;
  logic [RECS_W:0]       rec_inc;
  logic                  blk_done;
  logic [BINS_CFG_W-1:0] bins_wr;
  logic [AW-1:0]         mod_addr;
  entry_t                ent;

  assign in_full = clr_busy_i || ((int'(q_level_i) + int'(a_valid_r)) >= QUEUE_DEPTH);
  assign accept  = in_push && !in_full;
  assign bins_wr = cfg_data[BINS_CFG_W-1:0];

  always_comb begin
    case (in_action)
      ACT_ACCUM: op_in = ACT_ACCUM;
      ACT_CLEAR: op_in = ACT_CLEAR;
      default:   op_in = ACT_READ;
    endcase
  end

  // record position; a stale position (bins lowered mid-record) restarts at bin 0
  always_comb begin
    pos_cur  = (NBW'(pos_r) >= bins_eff_r) ? '0 : pos_r;
    pos_inc  = NBW'(pos_cur) + NBW'(1);
    rec_inc  = {1'b0, rec_r} + (RECS_W + 1)'(1);
    rec_wrap = 1'b0;
    pos_nxt  = pos_r;
    rec_nxt  = rec_r;
    if (pos_inc >= bins_eff_r) begin
      pos_nxt  = '0;
      rec_wrap = (rec_inc >= {1'b0, recs_eff_r});
      rec_nxt  = rec_wrap ? '0 : rec_inc[RECS_W-1:0];
    end else begin
      pos_nxt = AW'(pos_inc);
    end
    blk_done = rec_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_eff_r <= NBW'(BINS_RST);
      recs_eff_r <= RECS_W'(RECS_CFG_RESET);
      pos_r      <= '0;
      rec_r      <= '0;
      a_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_BINS: begin
            if (bins_wr == '0) begin
              bins_eff_r <= NBW'(1);
            end else if (int'(bins_wr) > MAX_BINS) begin
              bins_eff_r <= NBW'(MAX_BINS);
            end else begin
              bins_eff_r <= NBW'(bins_wr);
            end
          end
          CFG_IDX_RECS: begin
            recs_eff_r <= (cfg_data[RECS_W-1:0] == '0) ? RECS_W'(1) : cfg_data[RECS_W-1:0];
          end
          default: ;
        endcase
      end
      if (accept && op_in == ACT_ACCUM) begin
        pos_r <= pos_nxt;
        rec_r <= rec_nxt;
      end
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op_r     <= op_in;
      a_sample_r <= in_sample;
      a_pos_r    <= pos_cur;
      a_sel_r    <= in_bin_select;
      a_done_r   <= blk_done && (op_in == ACT_ACCUM);
    end
  end

  // bin_select modulo MAX_BINS
  generate
    if (MAX_BINS < (1 << SEL_W)) begin : g_mod
      // reciprocal multiply, one correction step
      localparam int RSH   = 24;
      localparam int RECIP = (1 << RSH) / MAX_BINS;
      localparam int PW    = SEL_W + RSH;
      localparam int RW    = SEL_W + 1;

      logic [PW-1:0]    prod_r;
      logic [SEL_W-1:0] quo;
      logic [RW-1:0]    rem1;
      logic [RW-1:0]    rem2;

      always_ff @(posedge clk) begin
        if (accept) begin
          prod_r <= PW'(in_bin_select) * PW'(RECIP);
        end
      end

      always_comb begin
        quo  = prod_r[PW-1:RSH];
        rem1 = RW'(a_sel_r) - RW'(int'(quo) * MAX_BINS);
        rem2 = (rem1 >= RW'(MAX_BINS)) ? (rem1 - RW'(MAX_BINS)) : rem1;
      end

      assign mod_addr = AW'(rem2);
    end else begin : g_nomod
      assign mod_addr = AW'(a_sel_r);
    end
  endgenerate

  always_comb begin
    ent.op     = a_op_r;
    ent.addr   = (a_op_r == ACT_ACCUM) ? a_pos_r : mod_addr;
    ent.sample = a_sample_r;
    ent.done   = a_done_r;
  end

  assign q_push_o = a_valid_r;
  assign q_data_o = ent;

  `RSA_ASSERT_IMP(a_queue_room, q_push_o, (int'(q_level_i) < QUEUE_DEPTH),
    "front pushed into a full queue")
  `RSA_ASSERT_NXT(a_block_end_clears, (accept && op_in == ACT_ACCUM && blk_done),
    (pos_r == '0 && rec_r == '0), "block end left counters nonzero")

endmodule

`default_nettype wire

[src/rsa_queue.sv]
`default_nettype none

module rsa_queue
  import rsa_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_i,
  input  wire logic [WIDTH-1:0]  data_i,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output logic [WIDTH-1:0]       data_o,
  output logic [QLVL_W-1:0]      level_o
);

  logic [WIDTH-1:0]  slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QLVL_W-1:0] count_r;
  logic              do_pop;

  assign valid_o = (count_r != '0);
  assign data_o  = slot_r[rd_ptr_r];
  assign level_o = count_r;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   count_r <= count_r + QLVL_W'(1);
        2'b01:   count_r <= count_r - QLVL_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

`default_nettype wire

[src/rsa_back.sv]
`default_nettype none

`include "record_sum_averager_unit_macros.svh"

module rsa_back
  import rsa_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   q_valid_i,
  input  wire logic [entry_w(MAX_BINS, SAMPLE_BITS)-1:0] q_data_i,
  output logic                                        q_pop_o,
  output logic                                        clr_busy_o,
  output logic                                        out_empty,
  input  wire logic                                   out_pop,
  output logic [BIN_INDEX_W-1:0]                      out_bin_index,
  output logic signed [BIN_SUM_W-1:0]                 out_bin_sum,
  output logic                                        out_block_done
);

  localparam int AW = $clog2(MAX_BINS);

  typedef struct packed {
    logic [ACTION_W-1:0]           op;
    logic [AW-1:0]                 addr;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          done;
  } entry_t;

  logic [SUM_BITS-1:0] acc_mem [MAX_BINS];

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic   s1_valid_r, s2_valid_r, out_valid_r;
  entry_t q_e, s1_r, s2_r;

  logic [SUM_BITS-1:0] rd_data_r;
  logic                fwd_valid_r;
  logic [AW-1:0]       fwd_addr_r;
  logic [SUM_BITS-1:0] fwd_data_r;

  logic [AW-1:0]       out_addr_r;
  logic [SUM_BITS-1:0] out_sum_r;
  logic                out_done_r;
  logic [ACTION_W-1:0] out_op_r;

  logic                adv;
  logic                fwd_hit;
  logic                wr_en;
  logic [SUM_BITS-1:0] old_sum;
  logic [SUM_BITS-1:0] new_sum;

  assign q_e     = entry_t'(q_data_i);
  assign adv     = !out_valid_r || out_pop;
  assign q_pop_o = adv && q_valid_i;

  // the write from the previous advance is not yet visible in rd_data_r
  assign fwd_hit = fwd_valid_r && (fwd_addr_r == s2_r.addr);
  assign old_sum = fwd_hit ? fwd_data_r : rd_data_r;
  assign wr_en   = adv && s2_valid_r && (s2_r.op != ACT_READ);

  always_comb begin
    case (s2_r.op)
      ACT_ACCUM: new_sum = old_sum + SUM_BITS'($signed(s2_r.sample));
      ACT_CLEAR: new_sum = '0;
      default:   new_sum = old_sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_BINS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (adv) begin
        s1_valid_r  <= q_valid_i;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
        fwd_valid_r <= wr_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= q_e;
      s2_r       <= s1_r;
      out_addr_r <= s2_r.addr;
      out_sum_r  <= new_sum;
      out_done_r <= s2_r.done;
      out_op_r   <= s2_r.op;
      fwd_addr_r <= s2_r.addr;
      fwd_data_r <= new_sum;
    end
  end

  // accumulator store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      acc_mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      acc_mem[s2_r.addr] <= new_sum;
    end
    if (adv) begin
      rd_data_r <= acc_mem[s1_r.addr];
    end
  end

  assign clr_busy_o     = clr_busy_r;
  assign out_empty      = !out_valid_r;
  assign out_bin_index  = BIN_INDEX_W'(out_addr_r);
  assign out_bin_sum    = BIN_SUM_W'($signed(out_sum_r));
  assign out_block_done = out_done_r;

  `RSA_ASSERT_IMP(a_clear_pass_idle, clr_busy_r,
    (!s1_valid_r && !s2_valid_r && !out_valid_r), "item in flight during clear pass")
  `RSA_ASSERT_IMP(a_clear_gives_zero, (out_valid_r && out_op_r == ACT_CLEAR),
    (out_sum_r == '0), "cleared bin reports nonzero sum")
  `RSA_ASSERT_IMP(a_done_on_accum, (out_valid_r && out_done_r),
    (out_op_r == ACT_ACCUM), "block flag on read or clear")

endmodule

`default_nettype wire
